[hdl/stid_pkg.sv]
// Package for the typed sorted identifier table: sizes, status codes and
// the command and status structs between the controller and the datapath.
// No dependencies; every other file of the block imports it.
package stid_pkg;

    localparam int TYPE_COUNT     = 16;
    localparam int SLOTS_PER_TYPE = 64;
    localparam int KEY_WIDTH      = 32;
    localparam int DATA_WIDTH     = 32;

    localparam int OP_W        = 1;
    localparam int TYPE_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 6;
    localparam int COUNT_OUT_W = 7;

    localparam int TYPE_IDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int SLOT_W     = $clog2(SLOTS_PER_TYPE);
    localparam int CNT_W      = $clog2(SLOTS_PER_TYPE + 1);
    localparam int ADDR_W     = TYPE_IDX_W + SLOT_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int ENTRY_W    = KEY_WIDTH + DATA_WIDTH;

    localparam int S_TDATA_W = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W + TYPE_W;
    localparam int M_TDATA_W = ((STATUS_W + SLOT_OUT_W + COUNT_OUT_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef struct packed {
        logic load;
        logic prime;
        logic walk;
        logic tail;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_stop;
        logic walk_last;
        logic no_entries;
        logic out_busy;
    } dp_status_t;

endpackage

[hdl/typed_sorted_id_table_top.sv]
// Top level of the typed sorted identifier table.
// Joins the controller stid_ctrl and the datapath stid_dpath; uses stid_pkg.
//
// Channel  Direction  Carries
// s_       in         tuser {comp_type, op}, tdata {payload, entity_id}
// m_       out        tdata {entry_count, slot_index, status}
//
// The list walk reads one slot per cycle from the single-read slot memory.
// A new item is taken once the previous result sits in the output register.
// Reset clears the fill counts and the output valid; the slot memory keeps
// its contents and needs no clearing pass. A stalled output holds its transfer.
module typed_sorted_id_table_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stid_pkg::S_TDATA_W-1:0] s_tdata,  // entity_id, payload
    input  logic [stid_pkg::S_TUSER_W-1:0] s_tuser,  // op, comp_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stid_pkg::M_TDATA_W-1:0] m_tdata   // status, slot_index, entry_count
);
    import stid_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    stid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stid_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/stid_ctrl.sv]
// Controller state machine of the typed sorted identifier table.
// Sequences load, list walk, tail write and result hand-off; uses stid_pkg.
module stid_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  stid_pkg::dp_status_t status,
    output stid_pkg::ctrl_cmd_t  cmd
);
    import stid_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PRIME = 5'b00010,
        S_WALK  = 5'b00100,
        S_TAIL  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PRIME;
                end
            end
            S_PRIME: begin
                cmd.prime  = 1'b1;
                state_next = status.no_entries ? S_TAIL : S_WALK;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_stop) begin
                    state_next = S_DONE;
                end else if (status.walk_last) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                cmd.tail   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/stid_dpath.sv]
// Datapath of the typed sorted identifier table: slot memory, fill counts,
// walk counters, carry register and the output register. Uses stid_pkg.
module stid_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [stid_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [stid_pkg::S_TUSER_W-1:0] s_tuser,
    input  stid_pkg::ctrl_cmd_t            cmd,
    output stid_pkg::dp_status_t           status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stid_pkg::M_TDATA_W-1:0] m_tdata
);
    import stid_pkg::*;

    logic [ENTRY_W-1:0]    mem [0:MEM_DEPTH-1];
    logic [CNT_W-1:0]      fill_reg [0:TYPE_COUNT-1];

    op_t                   op_reg;
    logic [TYPE_W-1:0]     type_reg;
    logic                  bad_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [CNT_W-1:0]      fill_cur_reg;
    logic [CNT_W-1:0]      rd_idx_reg;
    logic [SLOT_W-1:0]     cmp_idx_reg;
    logic                  shifting_reg;
    logic [SLOT_W-1:0]     pos_reg;
    logic [ENTRY_W-1:0]    hold_reg;
    logic [ENTRY_W-1:0]    rd_entry_reg;
    status_t               res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [CNT_W-1:0]      res_count_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [TYPE_W-1:0]     in_type;
    logic                  in_bad;
    logic [TYPE_IDX_W-1:0] tidx;
    logic [KEY_WIDTH-1:0]  rd_key;
    logic                  eq;
    logic                  gt;
    logic                  last;
    logic                  full;
    logic                  start_shift;
    logic                  we;
    logic [SLOT_W-1:0]     wslot;
    logic [ENTRY_W-1:0]    wentry;
    logic [ENTRY_W-1:0]    new_entry;

    assign in_type   = s_tuser[OP_W +: TYPE_W];
    assign in_bad    = 32'(in_type) >= TYPE_COUNT;
    assign tidx      = TYPE_IDX_W'(type_reg);
    assign rd_key    = rd_entry_reg[DATA_WIDTH +: KEY_WIDTH];
    assign eq        = rd_key == key_reg;
    assign gt        = rd_key > key_reg;
    assign last      = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == fill_cur_reg;
    assign full      = fill_cur_reg == CNT_W'(SLOTS_PER_TYPE);
    assign new_entry = {key_reg, data_reg};
    assign start_shift = (op_reg == OP_INSERT) && !shifting_reg && !eq && gt && !full;

    assign status.walk_stop  = (op_reg == OP_INSERT) && !shifting_reg && (eq || (gt && full));
    assign status.walk_last  = last;
    assign status.no_entries = fill_cur_reg == '0;
    assign status.out_busy   = m_tvalid_reg && !m_tready;

    always_comb begin
        we     = 1'b0;
        wslot  = cmp_idx_reg;
        wentry = new_entry;
        if (cmd.walk) begin
            if (op_reg == OP_INSERT) begin
                if (shifting_reg) begin
                    we     = 1'b1;
                    wentry = hold_reg;
                end else if (start_shift) begin
                    we = 1'b1;
                end
            end else if (shifting_reg) begin
                we     = 1'b1;
                wslot  = cmp_idx_reg - SLOT_W'(1);
                wentry = rd_entry_reg;
            end
        end else if (cmd.tail && (op_reg == OP_INSERT) && !bad_reg
                     && (shifting_reg || !full)) begin
            we     = 1'b1;
            wslot  = fill_cur_reg[SLOT_W-1:0];
            wentry = shifting_reg ? hold_reg : new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[{tidx, wslot}] <= wentry;
        end
        rd_entry_reg <= mem[{tidx, rd_idx_reg[SLOT_W-1:0]}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= op_t'(s_tuser[0]);
            type_reg     <= in_type;
            bad_reg      <= in_bad;
            key_reg      <= s_tdata[KEY_WIDTH-1:0];
            data_reg     <= s_tdata[KEY_WIDTH +: DATA_WIDTH];
            fill_cur_reg <= in_bad ? '0 : fill_reg[TYPE_IDX_W'(in_type)];
            rd_idx_reg   <= '0;
            cmp_idx_reg  <= '0;
            shifting_reg <= 1'b0;
            pos_reg      <= '0;
        end
        if (cmd.prime) begin
            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
        end
        if (cmd.walk) begin
            rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
            cmp_idx_reg <= cmp_idx_reg + SLOT_W'(1);
            if (op_reg == OP_INSERT) begin
                if (shifting_reg) begin
                    hold_reg <= rd_entry_reg;
                end else if (start_shift) begin
                    shifting_reg <= 1'b1;
                    pos_reg      <= cmp_idx_reg;
                    hold_reg     <= rd_entry_reg;
                end
                if (!shifting_reg && eq) begin
                    res_status_reg <= ST_DUPLICATE;
                    res_slot_reg   <= cmp_idx_reg;
                    res_count_reg  <= fill_cur_reg;
                end else if (!shifting_reg && gt && full) begin
                    res_status_reg <= ST_FULL;
                    res_slot_reg   <= '0;
                    res_count_reg  <= fill_cur_reg;
                end
            end else if (!shifting_reg && eq) begin
                shifting_reg <= 1'b1;
                pos_reg      <= cmp_idx_reg;
            end
        end
        if (cmd.tail) begin
            if (op_reg == OP_INSERT) begin
                if (bad_reg || (!shifting_reg && full)) begin
                    res_status_reg <= ST_FULL;
                    res_slot_reg   <= '0;
                    res_count_reg  <= fill_cur_reg;
                end else begin
                    res_status_reg <= ST_INSERTED;
                    res_slot_reg   <= shifting_reg ? pos_reg : fill_cur_reg[SLOT_W-1:0];
                    res_count_reg  <= fill_cur_reg + CNT_W'(1);
                end
            end else if (shifting_reg) begin
                res_status_reg <= ST_DELETED;
                res_slot_reg   <= pos_reg;
                res_count_reg  <= fill_cur_reg - CNT_W'(1);
            end else begin
                res_status_reg <= ST_NOT_FOUND;
                res_slot_reg   <= '0;
                res_count_reg  <= fill_cur_reg;
            end
        end
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({COUNT_OUT_W'(res_count_reg),
                                       SLOT_OUT_W'(res_slot_reg),
                                       res_status_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TYPE_COUNT; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (cmd.tail && !bad_reg) begin
            if ((op_reg == OP_INSERT) && (shifting_reg || !full)) begin
                fill_reg[tidx] <= fill_cur_reg + CNT_W'(1);
            end else if ((op_reg == OP_DELETE) && shifting_reg) begin
                fill_reg[tidx] <= fill_cur_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/stid_checker.sv]
// Port-level checker for the typed sorted identifier table, bound to
// typed_sorted_id_table_top. Uses stid_pkg for widths and status codes.
module stid_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [stid_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [stid_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [stid_pkg::M_TDATA_W-1:0] m_tdata
);
    import stid_pkg::*;

    logic [STATUS_W-1:0]    st;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [COUNT_OUT_W-1:0] count;

    assign st    = m_tdata[STATUS_W-1:0];
    assign slot  = m_tdata[STATUS_W +: SLOT_OUT_W];
    assign count = m_tdata[STATUS_W + SLOT_OUT_W +: COUNT_OUT_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Output transfer changed while stalled.");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("Input taken again or result produced too early.");

    a_slot_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_INSERTED || st == ST_DUPLICATE)
        |-> ({1'b0, slot} < count))
        else $error("Slot index outside the list.");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_FULL || st == ST_NOT_FOUND) |-> slot == '0)
        else $error("Slot index must be zero for full or not found.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st == ST_INSERTED || st == ST_DUPLICATE || st == ST_DELETED
                      || st == ST_NOT_FOUND || st == ST_FULL))
        else $error("Unknown status code.");

endmodule

bind typed_sorted_id_table_top stid_checker u_stid_checker (.*);
